[rtl/core/gss_pkg.sv]
// Package with the types and constants shared by the gain search sequencer files.
package gss_pkg;

    localparam int DUR_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_CFG    = 4;
    localparam int OUT_IDX_W  = 2;
    localparam int OUT_VAL_W  = 32;
    localparam int SHRINK_W   = 6;

    localparam logic [SHRINK_W-1:0] SHRINK_MAX = 6'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_KP_TRANS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_TRANS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_ROT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_ROT   = 2'd3;

    localparam logic [CFG_W-1:0] RST_KP_TRANS = 32'd34;
    localparam logic [CFG_W-1:0] RST_KD_TRANS = 32'd12;
    localparam logic [CFG_W-1:0] RST_KP_ROT   = 32'd130;
    localparam logic [CFG_W-1:0] RST_KD_ROT   = 32'd288;

    typedef enum logic [3:0] {
        PH_INIT        = 4'd0,
        PH_LAUNCH      = 4'd1,
        PH_SAVE        = 4'd2,
        PH_GROW        = 4'd3,
        PH_GROW_CMP    = 4'd4,
        PH_SHRINK      = 4'd5,
        PH_SHRINK_CMP  = 4'd6,
        PH_REFINE      = 4'd7,
        PH_PLUS        = 4'd8,
        PH_MINUS       = 4'd9,
        PH_JUDGE_MINUS = 4'd10,
        PH_NEXT        = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        ALU_GROW   = 2'd0,
        ALU_SHRINK = 2'd1,
        ALU_PLUS   = 2'd2,
        ALU_MINUS  = 2'd3
    } t_alu_op;

endpackage

[rtl/core/gss_if.sv]
// Valid/ready channel interfaces for the measured duration input and the trial output.
interface gss_in_if import gss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] measured_duration;

    modport source (output valid, output measured_duration, input ready);
    modport sink (input valid, input measured_duration, output ready);
endinterface

interface gss_out_if import gss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 trial_valid;
    logic [OUT_IDX_W-1:0] gain_index;
    logic [OUT_VAL_W-1:0] gain_value;

    modport source (output valid, output trial_valid, output gain_index, output gain_value,
                    input ready);
    modport sink (input valid, input trial_valid, input gain_index, input gain_value,
                  output ready);
endinterface

[rtl/core/gain_search_sequencer_core.sv]
// Top level of the gain search sequencer that tunes controller gains by coordinate search.
//
// Usage: each item on i_meas carries the measured duration of the trial that the
// block proposed before; lower is better. For every input item exactly one item
// leaves on o_trial, telling whether a new trial gain is proposed, which gain it
// is and its value. The gains are tuned one after another, cyclically: growth by
// powers of two, then shrinking by powers of two, then refinement by fractions.
// The starting gains come from the write port i_cfg_we/i_cfg_idx/i_cfg_data and
// are read by the first item after reset only.
// Timing: an accepted item is held in an input register while the step logic
// runs, and its result then moves into the output register. While o_trial.ready
// stays high, one item is taken every cycle; the whole step is a single pass of
// shifts, adds and compares between the input and output registers.
// Reset (synchronous, active low) restores the starting gains to their defaults,
// empties both registers and restarts the search at its initial phase.
// When the receiver stalls, the result waits in the output register while one
// more item can be taken into the input register; after that i_meas.ready drops.
module gain_search_sequencer_core import gss_pkg::*; #(
    parameter int NUM_GAINS    = 4,
    parameter int MAX_GROW_LOG = 12,
    parameter int REFINE_LOG   = 4,
    parameter int GAIN_WIDTH   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gss_in_if.sink               i_meas,
    gss_out_if.source            o_trial,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AGW      = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
    localparam int GS_MAX   = (MAX_GROW_LOG > REFINE_LOG) ? MAX_GROW_LOG : REFINE_LOG;
    localparam int GSW      = $clog2(GS_MAX + 1);

    logic [CFG_W-1:0]      r_cfg [NUM_CFG];
    logic [GAIN_WIDTH-1:0] r_best_gains [NUM_GAINS];

    logic                  r_in_vld;
    logic [DUR_W-1:0]      r_dur;
    logic                  r_out_vld;
    logic                  r_out_trial;
    logic [OUT_IDX_W-1:0]  r_out_idx;
    logic [OUT_VAL_W-1:0]  r_out_val;

    t_phase                r_phase, n_phase;
    logic [AGW-1:0]        r_active, n_active;
    logic [GSW-1:0]        r_grow_shift, n_grow_shift;
    logic [SHRINK_W-1:0]   r_shrink_shift, n_shrink_shift;
    logic [GAIN_WIDTH-1:0] r_offset, n_offset;
    logic [GAIN_WIDTH-1:0] r_trial, n_trial;
    logic [DUR_W-1:0]      r_best_dur, n_best_dur;

    logic                  adv;
    logic                  emit;
    logic                  adopt;
    logic                  better;
    logic [GAIN_WIDTH-1:0] best;
    logic [GSW-1:0]        gs_inc;
    logic [GSW-1:0]        gs_dec;
    logic [SHRINK_W-1:0]   ss_inc;
    t_alu_op               alu_op;
    logic [GSW-1:0]        alu_gs;
    logic [GAIN_WIDTH-1:0] alu_value;
    logic [GAIN_WIDTH-1:0] alu_offset;
    logic [AGW-1:0]        active_wrap;

    assign adv            = r_in_vld && (!r_out_vld || o_trial.ready);
    assign i_meas.ready   = !r_in_vld || adv;
    assign o_trial.valid       = r_out_vld;
    assign o_trial.trial_valid = r_out_trial;
    assign o_trial.gain_index  = r_out_idx;
    assign o_trial.gain_value  = r_out_val;

    assign best    = r_best_gains[r_active];
    assign better  = r_dur < r_best_dur;
    assign gs_inc  = r_grow_shift + 1'b1;
    assign gs_dec  = r_grow_shift - 1'b1;
    assign ss_inc  = (r_shrink_shift < SHRINK_MAX) ? r_shrink_shift + 1'b1 : r_shrink_shift;
    assign alu_gs  = (r_phase == PH_PLUS) ? gs_dec : gs_inc;
    assign active_wrap = ({1'b0, r_active} + 1'b1 < (AGW + 1)'(NUM_GAINS)) ?
                         r_active + 1'b1 : '0;

    always_comb begin
        case (r_phase)
            PH_GROW:   alu_op = ALU_GROW;
            PH_SHRINK: alu_op = ALU_SHRINK;
            PH_PLUS:   alu_op = ALU_PLUS;
            PH_MINUS:  alu_op = ALU_MINUS;
            default:   alu_op = ALU_GROW;
        endcase
    end

    gss_gain_alu #(
        .GAIN_WIDTH (GAIN_WIDTH),
        .REFINE_LOG (REFINE_LOG),
        .GSW        (GSW)
    ) u_alu (
        .i_op           (alu_op),
        .i_best         (best),
        .i_grow_shift   (alu_gs),
        .i_shrink_shift (ss_inc),
        .i_offset       (r_offset),
        .o_value        (alu_value),
        .o_offset       (alu_offset)
    );

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_INIT:        n_phase = PH_LAUNCH;
            PH_LAUNCH:      n_phase = PH_SAVE;
            PH_SAVE:        n_phase = PH_GROW;
            PH_GROW:        n_phase = (gs_inc < GSW'(MAX_GROW_LOG)) ? PH_GROW_CMP : PH_SHRINK;
            PH_GROW_CMP:    n_phase = better ? PH_GROW : PH_SHRINK;
            PH_SHRINK:      n_phase = (alu_value != '0) ? PH_SHRINK_CMP : PH_REFINE;
            PH_SHRINK_CMP:  n_phase = better ? PH_SHRINK : PH_REFINE;
            PH_REFINE:      n_phase = PH_PLUS;
            PH_PLUS:        n_phase = (r_grow_shift != '0) ? PH_MINUS : PH_NEXT;
            PH_MINUS:       n_phase = better ? PH_PLUS : PH_JUDGE_MINUS;
            PH_JUDGE_MINUS: n_phase = PH_PLUS;
            PH_NEXT:        n_phase = PH_LAUNCH;
            default:        n_phase = PH_INIT;
        endcase
    end

    always_comb begin
        n_active       = r_active;
        n_grow_shift   = r_grow_shift;
        n_shrink_shift = r_shrink_shift;
        n_offset       = r_offset;
        n_trial        = r_trial;
        n_best_dur     = r_best_dur;
        emit           = 1'b0;
        adopt          = 1'b0;
        case (r_phase)
            PH_INIT: begin
                n_active = '0;
            end
            PH_LAUNCH: begin
                n_trial        = best;
                n_grow_shift   = '0;
                n_shrink_shift = '0;
                emit           = 1'b1;
            end
            PH_SAVE: begin
                n_best_dur = r_dur;
            end
            PH_GROW: begin
                n_grow_shift = gs_inc;
                n_trial      = alu_value;
                emit         = 1'b1;
            end
            PH_SHRINK: begin
                n_shrink_shift = ss_inc;
                n_trial        = alu_value;
                emit           = 1'b1;
            end
            PH_GROW_CMP, PH_SHRINK_CMP, PH_JUDGE_MINUS: begin
                adopt = better;
            end
            PH_REFINE: begin
                n_grow_shift = GSW'(REFINE_LOG);
            end
            PH_PLUS: begin
                if (r_grow_shift != '0) begin
                    n_grow_shift = gs_dec;
                    n_offset     = alu_offset;
                    n_trial      = alu_value;
                    emit         = 1'b1;
                end
            end
            PH_MINUS: begin
                if (better) begin
                    adopt = 1'b1;
                end else begin
                    n_trial = alu_value;
                    emit    = 1'b1;
                end
            end
            PH_NEXT: begin
                n_active = active_wrap;
            end
            default: begin
                adopt = 1'b0;
            end
        endcase
        if (adopt) begin
            n_best_dur = r_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_KP_TRANS] <= RST_KP_TRANS;
            r_cfg[CFG_KD_TRANS] <= RST_KD_TRANS;
            r_cfg[CFG_KP_ROT]   <= RST_KP_ROT;
            r_cfg[CFG_KD_ROT]   <= RST_KD_ROT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP_TRANS: r_cfg[CFG_KP_TRANS] <= i_cfg_data;
                CFG_KD_TRANS: r_cfg[CFG_KD_TRANS] <= i_cfg_data;
                CFG_KP_ROT:   r_cfg[CFG_KP_ROT]   <= i_cfg_data;
                CFG_KD_ROT:   r_cfg[CFG_KD_ROT]   <= i_cfg_data;
                default:      r_cfg[CFG_KP_TRANS] <= r_cfg[CFG_KP_TRANS];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_phase == PH_INIT) begin
                for (int i = 0; i < NUM_GAINS; i++) begin
                    r_best_gains[i] <= (i < NUM_CFG) ?
                                       r_cfg[CFG_IDX_W'(i)][GAIN_WIDTH-1:0] : '0;
                end
            end else if (adopt) begin
                r_best_gains[r_active] <= r_trial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_INIT;
            r_active       <= '0;
            r_grow_shift   <= '0;
            r_shrink_shift <= '0;
            r_offset       <= '0;
            r_trial        <= '0;
            r_best_dur     <= '0;
        end else if (adv) begin
            r_phase        <= n_phase;
            r_active       <= n_active;
            r_grow_shift   <= n_grow_shift;
            r_shrink_shift <= n_shrink_shift;
            r_offset       <= n_offset;
            r_trial        <= n_trial;
            r_best_dur     <= n_best_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_meas.valid && i_meas.ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_meas.valid && i_meas.ready) begin
            r_dur <= i_meas.measured_duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_trial.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_trial <= emit;
            r_out_idx   <= emit ? OUT_IDX_W'(r_active) : '0;
            r_out_val   <= emit ? OUT_VAL_W'(n_trial) : '0;
        end
    end

    // An item that is waiting in the input register is never dropped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("Input item lost while the output was stalled.");

    // A result that proposes no trial carries zero index and value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_trial |-> r_out_idx == '0 && r_out_val == '0)
        else $error("Result without a trial carries nonzero fields.");

    // The growth phase is only entered below the growth limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_GROW |-> r_grow_shift < GSW'(MAX_GROW_LOG))
        else $error("Growth phase entered at the growth limit.");

    // The first step after reset always launches the first gain.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_phase == PH_INIT |=> r_phase == PH_LAUNCH && r_active == '0)
        else $error("Initial step did not launch the first gain.");

endmodule

[rtl/core/gss_gain_alu.sv]
// Gain arithmetic for the grow, shrink and refine trials of the gain search.
module gss_gain_alu import gss_pkg::*; #(
    parameter int GAIN_WIDTH = 32,
    parameter int REFINE_LOG = 4,
    parameter int GSW        = 5
) (
    input  t_alu_op               i_op,
    input  logic [GAIN_WIDTH-1:0] i_best,
    input  logic [GSW-1:0]        i_grow_shift,
    input  logic [SHRINK_W-1:0]   i_shrink_shift,
    input  logic [GAIN_WIDTH-1:0] i_offset,
    output logic [GAIN_WIDTH-1:0] o_value,
    output logic [GAIN_WIDTH-1:0] o_offset
);

    logic [GAIN_WIDTH-1:0] scaled;
    logic [GAIN_WIDTH-1:0] shrunk;

    assign scaled   = i_best << i_grow_shift;
    assign shrunk   = (i_shrink_shift >= SHRINK_W'(GAIN_WIDTH)) ? '0 : (i_best >> i_shrink_shift);
    assign o_offset = scaled >> REFINE_LOG;

    always_comb begin
        case (i_op)
            ALU_GROW:   o_value = scaled;
            ALU_SHRINK: o_value = shrunk;
            ALU_PLUS:   o_value = i_best + o_offset;
            ALU_MINUS:  o_value = i_best - i_offset;
            default:    o_value = '0;
        endcase
    end

endmodule
